// ===== rtl/core/bplm_pkg.sv =====
// ----------------------------------------------------------------------------
// Block pool list manager package
// Shared default pool size, action and status codes, sequencer states and cell types.
// ----------------------------------------------------------------------------
package bplm_pkg;

   localparam int NUM_BLOCKS_DEFAULT = 32;

   typedef enum logic [3:0] {
      ACT_ALLOC      = 4'd0,
      ACT_MARK_PEND  = 4'd1,
      ACT_MARK_USED  = 4'd2,
      ACT_FIRST_PEND = 4'd3,
      ACT_HEAD_USED  = 4'd4,
      ACT_NEXT       = 4'd5,
      ACT_FREE_TOP   = 4'd6,
      ACT_FREE_ANY   = 4'd7,
      ACT_FREE_ALL   = 4'd8,
      ACT_COUNT_USED = 4'd9,
      ACT_COUNT_FREE = 4'd10,
      ACT_COUNT_ALLOC = 4'd11
   } action_type;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   localparam logic [1:0] BS_FREE = 2'd0;
   localparam logic [1:0] BS_PEND = 2'd1;
   localparam logic [1:0] BS_USED = 2'd2;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_WALK,
      SEQ_APPLY,
      SEQ_REFRESH,
      SEQ_RESPOND
   } seq_state_type;

   // per-cycle command sent down the cell row
   typedef struct packed {
      logic       clear;      // reload reset contents
      logic       wr_status;
      logic       wr_link;
      logic [1:0] status_val;
   } cell_cmd_type;

endpackage

// ===== rtl/core/bplm_cell.sv =====
// ----------------------------------------------------------------------------
// Block pool list manager cell
// Holds one block descriptor: status and link. Answers a broadcast read
// by passing its entry along the row when its index matches.
// ----------------------------------------------------------------------------
module bplm_cell #(
   parameter int NUM_BLOCKS = bplm_pkg::NUM_BLOCKS_DEFAULT,
   parameter int IW = $clog2(NUM_BLOCKS),
   parameter int LW = $clog2(NUM_BLOCKS + 1),
   parameter int INDEX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bplm_pkg::cell_cmd_type  cmd,
   input  logic [IW-1:0]           wr_addr,
   input  logic [LW-1:0]           wr_link,
   input  logic [IW-1:0]           rd_addr,
   input  logic [IW-1:0]           rd2_addr,
   input  logic [1:0]              prev_status,
   input  logic [LW-1:0]           prev_link,
   input  logic [LW-1:0]           prev_link2,
   output logic [1:0]              pass_status,
   output logic [LW-1:0]           pass_link,
   output logic [LW-1:0]           pass_link2
);
   import bplm_pkg::*;

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
   localparam logic [LW-1:0] RST_LINK = LW'(INDEX + 1);

   logic [1:0]    status_ff;
   logic [LW-1:0] link_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         status_ff <= BS_FREE;
         link_ff   <= RST_LINK;
      end else if (wr_addr == MY_IDX) begin
         if (cmd.wr_status) status_ff <= cmd.status_val;
         if (cmd.wr_link)   link_ff   <= wr_link;
      end
   end

   assign pass_status = (rd_addr == MY_IDX) ? status_ff : prev_status;
   assign pass_link   = (rd_addr == MY_IDX) ? link_ff : prev_link;
   assign pass_link2  = (rd2_addr == MY_IDX) ? link_ff : prev_link2;
endmodule

// ===== rtl/core/block_pool_list_manager_unit.sv =====
// ----------------------------------------------------------------------------
// Block pool list manager unit
// Each action walks its list in the walk state, alloc and free any then write in
// the apply state and, where needed, the respond state, and the refresh state
// recounts the allocation list before the response is raised. One transaction at
// a time: the next request is taken only in idle once the response is accepted.
// Reset: all blocks free and chained on the free list, allocation list empty.
// ----------------------------------------------------------------------------
module block_pool_list_manager_unit #(
   parameter int NUM_BLOCKS = bplm_pkg::NUM_BLOCKS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [3:0] req_action,
   input  logic [4:0] req_block_index,
   input  logic [4:0] req_prev_index,
   input  logic       req_prev_given,
   input  logic [7:0] req_free_count,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [4:0] rsp_result_block,
   output logic [5:0] rsp_count
);
   import bplm_pkg::*;

   localparam int IW = $clog2(NUM_BLOCKS);
   localparam int LW = $clog2(NUM_BLOCKS + 1);
   localparam int CW = $clog2(NUM_BLOCKS + 2);
   localparam logic [LW-1:0] LNULL = LW'(NUM_BLOCKS);
   localparam logic [CW-1:0] NB_C = CW'(NUM_BLOCKS);

   // cell row
   cell_cmd_type  cmd;
   logic [IW-1:0] wr_addr, rd_addr, rd2_addr;
   logic [LW-1:0] wr_link;
   logic [1:0]    ch_status [NUM_BLOCKS+1];
   logic [LW-1:0] ch_link [NUM_BLOCKS+1];
   logic [LW-1:0] ch_link2 [NUM_BLOCKS+1];

   assign ch_status[0] = BS_FREE;
   assign ch_link[0]   = LNULL;
   assign ch_link2[0]  = LNULL;

   for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
      bplm_cell #(.NUM_BLOCKS(NUM_BLOCKS), .IW(IW), .LW(LW), .INDEX(g)) u_cell (
         .clock(clock), .reset(reset), .cmd(cmd), .wr_addr(wr_addr),
         .wr_link(wr_link), .rd_addr(rd_addr), .rd2_addr(rd2_addr),
         .prev_status(ch_status[g]), .prev_link(ch_link[g]),
         .prev_link2(ch_link2[g]), .pass_status(ch_status[g+1]),
         .pass_link(ch_link[g+1]), .pass_link2(ch_link2[g+1])
      );
   end

   logic [1:0]    rd_status;
   logic [LW-1:0] rd_link, rd_link2;
   assign rd_status = ch_status[NUM_BLOCKS];
   assign rd_link   = ch_link[NUM_BLOCKS];
   assign rd_link2  = ch_link2[NUM_BLOCKS];

   // control registers
   seq_state_type state_ff, state_in;
   action_type    act_ff, act_in;
   logic [4:0]    blk_ff, blk_in, prv_ff, prv_in;
   logic          pg_ff, pg_in;
   logic [7:0]    fc_ff, fc_in;
   logic [LW-1:0] free_head_ff, free_head_in, alloc_head_ff, alloc_head_in;
   logic [LW-1:0] tail_ff, tail_in;
   logic [CW-1:0] used_ff, used_in, total_ff, total_in;
   logic [LW-1:0] cur_ff, cur_in, prv_node_ff, prv_node_in;
   logic [CW-1:0] step_ff, step_in, cnt_ff, cnt_in;
   logic          found_ff, found_in;
   logic          rv_ff, rv_in;
   logic [1:0]    st_ff, st_in;
   logic [4:0]    res_ff, res_in;
   logic [5:0]    rc_ff, rc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         free_head_ff  <= '0;
         alloc_head_ff <= LNULL;
         tail_ff       <= LNULL;
         used_ff       <= '0;
         total_ff      <= '0;
         rv_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         alloc_head_ff <= alloc_head_in;
         tail_ff       <= tail_in;
         used_ff       <= used_in;
         total_ff      <= total_in;
         rv_ff         <= rv_in;
      end
      act_ff <= act_in; blk_ff <= blk_in; prv_ff <= prv_in; pg_ff <= pg_in;
      fc_ff <= fc_in; cur_ff <= cur_in; prv_node_ff <= prv_node_in;
      step_ff <= step_in; cnt_ff <= cnt_in; found_ff <= found_in;
      st_ff <= st_in; res_ff <= res_in; rc_ff <= rc_in;
   end

   logic cur_ok, blk_ok, prv_ok;
   assign cur_ok = cur_ff < LNULL;
   assign blk_ok = {3'b0, blk_ff} < (8'(NUM_BLOCKS) + 8'd0);
   assign prv_ok = {3'b0, prv_ff} < (8'(NUM_BLOCKS) + 8'd0);

   assign req_ready = (state_ff == SEQ_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_result_block = res_ff;
   assign rsp_count = rc_ff;

   always_comb begin
      state_in = state_ff; act_in = act_ff; blk_in = blk_ff; prv_in = prv_ff;
      pg_in = pg_ff; fc_in = fc_ff; free_head_in = free_head_ff;
      alloc_head_in = alloc_head_ff; tail_in = tail_ff; used_in = used_ff;
      total_in = total_ff; cur_in = cur_ff; prv_node_in = prv_node_ff;
      step_in = step_ff; cnt_in = cnt_ff; found_in = found_ff;
      rv_in = rv_ff; st_in = st_ff; res_in = res_ff; rc_in = rc_ff;
      cmd = '0; wr_addr = '0; wr_link = LNULL;
      rd_addr = cur_ff[IW-1:0]; rd2_addr = blk_ff[IW-1:0];
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            if (req_valid && req_ready) begin
               act_in = action_type'(req_action);
               blk_in = req_block_index; prv_in = req_prev_index;
               pg_in = req_prev_given; fc_in = req_free_count;
               st_in = ST_OK; res_in = '0; rc_in = '0;
               step_in = '0; cnt_in = '0; found_in = 1'b0;
               prv_node_in = LNULL;
               state_in = SEQ_WALK;
               case (action_type'(req_action))
                  ACT_COUNT_FREE: cur_in = free_head_ff;
                  default:        cur_in = alloc_head_ff;
               endcase
            end
         end
         SEQ_WALK: begin
            // one link per cycle along the list
            case (act_ff)
               ACT_FIRST_PEND: begin
                  if (!cur_ok || step_ff == NB_C) begin
                     st_in = ST_EMPTY; state_in = SEQ_REFRESH;
                  end else if (rd_status == BS_PEND) begin
                     res_in = 5'(cur_ff); state_in = SEQ_REFRESH;
                  end else begin
                     cur_in = rd_link; step_in = step_ff + 1'b1;
                  end
               end
               ACT_COUNT_USED, ACT_COUNT_FREE, ACT_COUNT_ALLOC: begin
                  if (!cur_ok || step_ff == NB_C) begin
                     rc_in = 6'(cnt_ff); state_in = SEQ_REFRESH;
                  end else begin
                     if (act_ff != ACT_COUNT_USED || rd_status == BS_USED)
                        cnt_in = cnt_ff + 1'b1;
                     cur_in = rd_link; step_in = step_ff + 1'b1;
                  end
               end
               ACT_FREE_TOP: begin
                  if (!cur_ok) begin
                     st_in = ST_EMPTY; state_in = SEQ_REFRESH;
                  end else if (fc_ff == 8'd0) begin
                     state_in = SEQ_REFRESH;
                  end else begin
                     cmd.wr_status = 1'b1; cmd.status_val = BS_FREE;
                     wr_addr = cur_ff[IW-1:0];
                     if ((CW'(step_ff) + 1'b1) < CW'(fc_ff > 8'(NUM_BLOCKS) ?
                           8'(NUM_BLOCKS) : fc_ff) && rd_link < LNULL
                           && (step_ff + 1'b1) < NB_C) begin
                        cur_in = rd_link; step_in = step_ff + 1'b1;
                     end else begin
                        cmd.wr_link = 1'b1; wr_link = free_head_ff;
                        alloc_head_in = rd_link;
                        free_head_in = alloc_head_ff;
                        state_in = SEQ_REFRESH;
                     end
                  end
               end
               ACT_FREE_ANY: begin
                  if (!blk_ok || (pg_ff && !prv_ok)) begin
                     st_in = ST_NOT_FOUND; state_in = SEQ_REFRESH;
                  end else if (pg_ff) begin
                     found_in = 1'b1; prv_node_in = LW'(prv_ff);
                     state_in = SEQ_APPLY;
                  end else if (!cur_ok || step_ff == NB_C) begin
                     st_in = ST_NOT_FOUND; state_in = SEQ_REFRESH;
                  end else if (cur_ff == LW'(blk_ff)) begin
                     found_in = 1'b1; state_in = SEQ_APPLY;
                  end else begin
                     prv_node_in = cur_ff; cur_in = rd_link;
                     step_in = step_ff + 1'b1;
                  end
               end
               ACT_ALLOC: begin
                  // walk to the tail first; cur_ff holds the candidate tail
                  // the walk also ends at the block to be popped, the free head
                  if (free_head_ff >= LNULL) begin
                     st_in = ST_EMPTY; state_in = SEQ_REFRESH;
                  end else if (!cur_ok) begin
                     prv_node_in = LNULL; state_in = SEQ_APPLY;
                  end else if (rd_link < LNULL && cur_ff != free_head_ff
                        && step_ff != NB_C) begin
                     cur_in = rd_link; step_in = step_ff + 1'b1;
                  end else begin
                     prv_node_in = cur_ff; state_in = SEQ_APPLY;
                  end
               end
               ACT_MARK_PEND, ACT_MARK_USED: begin
                  if (!blk_ok) st_in = ST_NOT_FOUND;
                  else begin
                     cmd.wr_status = 1'b1; wr_addr = blk_ff[IW-1:0];
                     cmd.status_val = (act_ff == ACT_MARK_PEND) ? BS_PEND : BS_USED;
                  end
                  state_in = SEQ_REFRESH;
               end
               ACT_HEAD_USED: begin
                  rd_addr = alloc_head_ff[IW-1:0];
                  if (alloc_head_ff < LNULL && rd_status == BS_USED)
                     res_in = 5'(alloc_head_ff);
                  else st_in = ST_EMPTY;
                  state_in = SEQ_REFRESH;
               end
               ACT_NEXT: begin
                  if (!blk_ok) st_in = ST_NOT_FOUND;
                  else if (rd_link2 < LNULL) res_in = 5'(rd_link2);
                  else st_in = ST_EMPTY;
                  state_in = SEQ_REFRESH;
               end
               ACT_FREE_ALL: begin
                  cmd.clear = 1'b1; free_head_in = '0; alloc_head_in = LNULL;
                  state_in = SEQ_REFRESH;
               end
               default: state_in = SEQ_REFRESH;
            endcase
            if (state_in == SEQ_REFRESH) begin
               cur_in = alloc_head_in; step_in = '0; cnt_in = '0;
               used_in = '0; tail_in = LNULL;
            end
         end
         SEQ_APPLY: begin
            if (act_ff == ACT_ALLOC) begin
               // pop free head, null its link, append
               rd_addr = free_head_ff[IW-1:0];
               cmd.wr_link = 1'b1; wr_addr = free_head_ff[IW-1:0];
               wr_link = LNULL;
               free_head_in = rd_link;
               res_in = 5'(free_head_ff);
               if (prv_node_ff >= LNULL) alloc_head_in = free_head_ff;
               else cur_in = prv_node_ff;  // tail link fixed next cycle
               state_in = (prv_node_ff >= LNULL) ? SEQ_REFRESH : SEQ_RESPOND;
            end else begin
               // free any: step 1 bypass predecessor
               if (prv_node_ff >= LNULL) alloc_head_in = rd_link2;
               else begin
                  cmd.wr_link = 1'b1; wr_addr = prv_node_ff[IW-1:0];
                  wr_link = rd_link2;
               end
               state_in = SEQ_RESPOND;
            end
            if (state_in == SEQ_REFRESH) begin
               cur_in = alloc_head_in; step_in = '0; cnt_in = '0;
               used_in = '0; tail_in = LNULL;
            end
         end
         SEQ_RESPOND: begin
            // second write of alloc or free any
            if (act_ff == ACT_ALLOC) begin
               cmd.wr_link = 1'b1; wr_addr = cur_ff[IW-1:0];
               wr_link = LW'(res_ff);
            end else begin
               cmd.wr_link = 1'b1; cmd.wr_status = 1'b1;
               cmd.status_val = BS_FREE; wr_addr = blk_ff[IW-1:0];
               wr_link = free_head_ff; free_head_in = LW'(blk_ff);
            end
            cur_in = alloc_head_ff; step_in = '0; cnt_in = '0;
            used_in = '0; tail_in = LNULL;
            state_in = SEQ_REFRESH;
         end
         SEQ_REFRESH: begin
            // recount the allocation list
            if (!cur_ok || step_ff == NB_C) begin
               total_in = cnt_ff; rv_in = 1'b1; state_in = SEQ_IDLE;
            end else begin
               if (rd_link < LNULL) tail_in = rd_link;
               else if (step_ff == '0 || tail_ff == LNULL) tail_in = cur_ff;
               if (step_ff == '0 && rd_link >= LNULL) tail_in = cur_ff;
               if (rd_status == BS_USED) used_in = used_ff + 1'b1;
               cnt_in = cnt_ff + 1'b1; cur_in = rd_link;
               step_in = step_ff + 1'b1;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != SEQ_IDLE) |-> !req_ready) else $error("accept while busy");
   a_rsp_after_refresh: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == SEQ_REFRESH)
      else $error("response without refresh");
   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (used_ff <= total_ff || state_ff == SEQ_REFRESH) && total_ff <= NB_C)
      else $error("list counts out of range");
   a_rsp_ok_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_result_block == 5'd0)
      else $error("result block with error status");
endmodule

// ===== dv/tb_block_pool_list_manager_unit.sv =====
// ----------------------------------------------------------------------------
// Block pool list manager unit testbench
// Drives directed and random transactions of every action through the
// request channel and checks each response against an in-bench model of the
// free list and the allocation list, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_block_pool_list_manager_unit;
   import bplm_pkg::*;

   localparam int NB = 32;
   localparam int NUM_RANDOM = 1300;

   typedef struct packed {
      logic [3:0] action;
      logic [4:0] block_index;
      logic [4:0] prev_index;
      logic       prev_given;
      logic [7:0] free_count;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] result_block;
      logic [5:0] count;
   } rsp_type;

   // directed row: request, whether a typed-in response applies, that response
   typedef struct packed {
      req_type req;
      logic    fixed;
      rsp_type rsp;
   } row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [3:0] req_action = '0;
   logic [4:0] req_block_index = '0;
   logic [4:0] req_prev_index = '0;
   logic       req_prev_given = 1'b0;
   logic [7:0] req_free_count = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [4:0] rsp_result_block;
   logic [5:0] rsp_count;

   block_pool_list_manager_unit #(.NUM_BLOCKS(NB)) dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // pool model
   logic [1:0] pool_status [NB];
   int         pool_link [NB];
   int         free_head, alloc_head;

   rsp_type    pending_rsp [$];
   int         mismatch_count = 0;
   int         rsp_seen = 0;
   int         action_seen [16];
   bit         calm = 1'b0;

   function automatic int link_of(int b);
      return (b < NB) ? pool_link[b] : NB;
   endfunction

   function automatic int tail_of();
      int n, s;
      n = alloc_head;
      s = 0;
      if (n >= NB) return NB;
      while (link_of(n) < NB && s < NB) begin
         n = link_of(n);
         s++;
      end
      return n;
   endfunction

   function automatic int list_len(int n, bit used_only);
      int c, s;
      c = 0;
      s = 0;
      while (n < NB && s < NB) begin
         if (!used_only || pool_status[n] == BS_USED) c++;
         n = pool_link[n];
         s++;
      end
      return c;
   endfunction

   function automatic void pool_reset();
      for (int i = 0; i < NB; i++) begin
         pool_status[i] = BS_FREE;
         pool_link[i] = i + 1;
      end
      free_head = 0;
      alloc_head = NB;
   endfunction

   function automatic rsp_type pool_apply(req_type r);
      rsp_type o;
      int n, t, p, i;
      bit found;
      o = '0;
      case (r.action)
         ACT_ALLOC: begin
            n = free_head;
            if (n >= NB) o.status = ST_EMPTY;
            else begin
               free_head = pool_link[n];
               pool_link[n] = NB;
               t = tail_of();
               if (t >= NB) alloc_head = n;
               else pool_link[t] = n;
               o.result_block = 5'(n);
            end
         end
         ACT_MARK_PEND: pool_status[r.block_index] = BS_PEND;
         ACT_MARK_USED: pool_status[r.block_index] = BS_USED;
         ACT_FIRST_PEND: begin
            o.status = ST_EMPTY;
            n = alloc_head;
            for (i = 0; i < NB && n < NB; i++) begin
               if (pool_status[n] == BS_PEND) begin
                  o.status = ST_OK;
                  o.result_block = 5'(n);
                  break;
               end
               n = pool_link[n];
            end
         end
         ACT_HEAD_USED: begin
            if (alloc_head < NB && pool_status[alloc_head] == BS_USED)
               o.result_block = 5'(alloc_head);
            else o.status = ST_EMPTY;
         end
         ACT_NEXT: begin
            n = pool_link[r.block_index];
            if (n < NB) o.result_block = 5'(n);
            else o.status = ST_EMPTY;
         end
         ACT_FREE_TOP: begin
            t = alloc_head;
            if (t >= NB) o.status = ST_EMPTY;
            else if (r.free_count != 0) begin
               n = t;
               pool_status[n] = BS_FREE;
               for (i = 1; i < r.free_count && i < NB && pool_link[n] < NB; i++) begin
                  n = pool_link[n];
                  pool_status[n] = BS_FREE;
               end
               alloc_head = pool_link[n];
               pool_link[n] = free_head;
               free_head = t;
            end
         end
         ACT_FREE_ANY: begin
            found = 1'b1;
            if (r.prev_given) pool_link[r.prev_index] = pool_link[r.block_index];
            else begin
               found = 1'b0;
               p = NB;
               n = alloc_head;
               for (i = 0; i < NB && n < NB; i++) begin
                  if (n == r.block_index) begin
                     found = 1'b1;
                     break;
                  end
                  p = n;
                  n = pool_link[n];
               end
               if (found) begin
                  if (p >= NB) alloc_head = pool_link[r.block_index];
                  else pool_link[p] = pool_link[r.block_index];
               end
            end
            if (found) begin
               pool_status[r.block_index] = BS_FREE;
               pool_link[r.block_index] = free_head;
               free_head = r.block_index;
            end else o.status = ST_NOT_FOUND;
         end
         ACT_FREE_ALL: pool_reset();
         ACT_COUNT_USED: o.count = 6'(list_len(alloc_head, 1'b1));
         ACT_COUNT_FREE: o.count = 6'(list_len(free_head, 1'b0));
         ACT_COUNT_ALLOC: o.count = 6'(list_len(alloc_head, 1'b0));
         default: ;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic send(req_type r, bit fixed, rsp_type want);
      rsp_type p;
      while (!calm && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      p = pool_apply(r);
      if (fixed && p != want) begin
         report_mismatch("typed response", p, want);
      end
      pending_rsp.push_back(p);
      action_seen[r.action]++;
      req_valid <= 1'b1;
      req_action <= r.action;
      req_block_index <= r.block_index;
      req_prev_index <= r.prev_index;
      req_prev_given <= r.prev_given;
      req_free_count <= r.free_count;
      do @(posedge clock); while (!req_ready);
   endtask

   // response side
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (pending_rsp.size() == 0) report_mismatch("unexpected response", 0, 0);
            else begin
               want = pending_rsp.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_result_block !== want.result_block)
                  report_mismatch("result_block", rsp_result_block, want.result_block);
               if (rsp_count !== want.count)
                  report_mismatch("count", rsp_count, want.count);
            end
         end
         rsp_ready <= calm || ($urandom_range(99) >= 18);
      end
   end

   function automatic req_type mk(action_type a, int b, int p, bit g, int f);
      req_type r;
      r.action = a;
      r.block_index = 5'(b);
      r.prev_index = 5'(p);
      r.prev_given = g;
      r.free_count = 8'(f);
      return r;
   endfunction

   function automatic rsp_type rs(int s, int b, int c);
      rsp_type o;
      o.status = 2'(s);
      o.result_block = 5'(b);
      o.count = 6'(c);
      return o;
   endfunction

   function automatic req_type random_req();
      req_type r;
      int k, n;
      r = '0;
      r.block_index = 5'($urandom);
      r.prev_index = 5'($urandom);
      r.prev_given = ($urandom_range(9) == 0);
      r.free_count = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(4));
      k = $urandom_range(99);
      if (k < 30) r.action = ACT_ALLOC;
      else if (k < 45) r.action = $urandom_range(1) ? ACT_MARK_PEND : ACT_MARK_USED;
      else if (k < 60) r.action = 4'($urandom_range(ACT_FIRST_PEND, ACT_NEXT));
      else if (k < 70) r.action = ACT_FREE_TOP;
      else if (k < 86) r.action = ACT_FREE_ANY;
      else if (k < 88) r.action = ACT_FREE_ALL;
      else r.action = 4'($urandom_range(ACT_COUNT_USED, ACT_COUNT_ALLOC));
      // aim marks, lookups and frees mostly at listed blocks, with a well-formed predecessor
      if (k >= 30 && k < 86 && alloc_head < NB && $urandom_range(3) != 0) begin
         n = alloc_head;
         for (int i = $urandom_range(NB - 1); i > 0 && link_of(n) < NB; i--) begin
            r.prev_index = 5'(n);
            n = link_of(n);
         end
         r.block_index = 5'(n);
         if (r.prev_given && n == alloc_head) r.prev_given = 1'b0;
      end
      return r;
   endfunction

   row_type directed [] = '{
      '{mk(ACT_COUNT_FREE, 0, 0, 0, 0), 1'b1, rs(ST_OK, 0, 32)},
      '{mk(ACT_COUNT_ALLOC, 0, 0, 0, 0), 1'b1, rs(ST_OK, 0, 0)},
      '{mk(ACT_FIRST_PEND, 0, 0, 0, 0), 1'b1, rs(ST_EMPTY, 0, 0)},
      '{mk(ACT_HEAD_USED, 0, 0, 0, 0), 1'b1, rs(ST_EMPTY, 0, 0)},
      '{mk(ACT_FREE_TOP, 0, 0, 0, 255), 1'b1, rs(ST_EMPTY, 0, 0)},
      '{mk(ACT_FREE_ANY, 31, 0, 0, 0), 1'b1, rs(ST_NOT_FOUND, 0, 0)},
      '{mk(ACT_NEXT, 31, 0, 0, 0), 1'b1, rs(ST_EMPTY, 0, 0)},
      '{mk(ACT_ALLOC, 0, 0, 0, 0), 1'b1, rs(ST_OK, 0, 0)},
      '{mk(ACT_ALLOC, 0, 0, 0, 0), 1'b1, rs(ST_OK, 1, 0)},
      '{mk(ACT_ALLOC, 0, 0, 0, 0), 1'b1, rs(ST_OK, 2, 0)},
      '{mk(ACT_MARK_USED, 0, 0, 0, 0), 1'b0, '0},
      '{mk(ACT_MARK_PEND, 2, 0, 0, 0), 1'b0, '0},
      '{mk(ACT_MARK_USED, 31, 0, 0, 0), 1'b0, '0},
      '{mk(ACT_HEAD_USED, 0, 0, 0, 0), 1'b0, '0},
      '{mk(ACT_FIRST_PEND, 0, 0, 0, 0), 1'b0, '0},
      '{mk(ACT_COUNT_USED, 0, 0, 0, 0), 1'b0, '0},
      '{mk(ACT_FREE_ANY, 1, 0, 0, 0), 1'b0, '0},
      '{mk(ACT_FREE_ANY, 2, 0, 1, 0), 1'b0, '0},
      '{mk(ACT_FREE_TOP, 0, 0, 0, 0), 1'b0, '0},
      '{mk(ACT_NEXT, 0, 0, 0, 0), 1'b0, '0},
      '{mk(ACT_FREE_TOP, 0, 0, 0, 255), 1'b0, '0},
      '{mk(ACT_FREE_ALL, 0, 0, 0, 0), 1'b1, rs(ST_OK, 0, 0)},
      '{mk(action_type'(4'd15), 31, 31, 1, 255), 1'b1, rs(ST_OK, 0, 0)},
      '{mk(ACT_COUNT_FREE, 0, 0, 0, 0), 1'b1, rs(ST_OK, 0, 32)}
   };

   initial begin
      int wait_cycles;
      pool_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send(directed[i].req, directed[i].fixed, directed[i].rsp);
      for (int i = 0; i < NUM_RANDOM; i++) begin
         calm = (i >= 400 && i < 550);
         send(random_req(), 1'b0, '0);
      end
      req_valid <= 1'b0;
      calm = 1'b0;
      wait_cycles = 0;
      while (pending_rsp.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (2 * NB + 8) @(posedge clock);
      $display("covered %0d responses; allocs %0d, free top %0d, free any %0d, free all %0d",
               rsp_seen, action_seen[ACT_ALLOC], action_seen[ACT_FREE_TOP],
               action_seen[ACT_FREE_ANY], action_seen[ACT_FREE_ALL]);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/bplm_pkg.sv
rtl/core/bplm_cell.sv
rtl/core/block_pool_list_manager_unit.sv
dv/tb_block_pool_list_manager_unit.sv
